/* rtl/bben_pkg.sv */
package bben_pkg;

  // default sizes of the storage
  localparam int WIDTH_MAX_DEF  = 1024;
  localparam int RADIUS_MAX_DEF = 8;

  // fixed field widths
  localparam int PIX_W      = 16;
  localparam int SUM_W      = 25;
  localparam int IW_W       = 11;
  localparam int IH_W       = 13;
  localparam int IR_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

endpackage

/* rtl/box_blur_edge_normalized.sv */
// A pixel that releases a result passes ST_MUL, ST_CMP, ST_WRAP, ST_WIN, ST_PREP, then
// ST_SUM reads the N = rows x columns clipped window entries, one row store entry per
// cycle, then a 25-step serial divide for the mean, ST_FIN and ST_OUT (a releasing drain
// starts at ST_WRAP). One transaction at a time: a pixel with no result passes ST_MUL
// and ST_CMP, a drain with nothing pending stays idle; a result held back by out_ready stalls input
// reset (rst, synchronous): counters zero, width 1024, height 1024, radius 1; store kept
module box_blur_edge_normalized import bben_pkg::*; #(
  parameter int WIDTH_MAX  = WIDTH_MAX_DEF,
  parameter int RADIUS_MAX = RADIUS_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [PIX_W-1:0]      pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel_out,
  output logic                  frame_last
);

  localparam int RING  = 2 * RADIUS_MAX + 1;
  localparam int RW    = $clog2(RING);
  localparam int CW    = $clog2(WIDTH_MAX + 1);
  localparam int XW    = $clog2(WIDTH_MAX);
  localparam int DEPTH = RING * WIDTH_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(RING * RING + 1);
  localparam int PW    = IH_W + CW + 2;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_MUL  = 12'b000000000010,
    ST_CMP  = 12'b000000000100,
    ST_WRAP = 12'b000000001000,
    ST_WIN  = 12'b000000010000,
    ST_PREP = 12'b000000100000,
    ST_SUM  = 12'b000001000000,
    ST_SUMW = 12'b000010000000,
    ST_DIVS = 12'b000100000000,
    ST_DIVW = 12'b001000000000,
    ST_FIN  = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [IW_W-1:0] image_width;
  logic [IH_W-1:0] image_height;
  logic [IR_W-1:0] radius;

  // position counters
  logic [CW-1:0]   in_column, out_column;
  logic [IH_W-1:0] in_row, out_row;
  logic [RW-1:0]   in_ring, out_ring;

  // window bounds and scan
  logic [IH_W-1:0] rlo, rhi, rr;
  logic [CW-1:0]   clo, chi, col;
  logic [RW-1:0]   ring_start, ri;
  logic            rd_pending;
  logic [SUM_W-1:0] sum;
  logic [NW-1:0]   count;
  logic [PIX_W-1:0] value;
  logic            is_last;

  // rate check products
  logic [PW-1:0] prod_in, prod_out, lag;

  // effective register values
  logic [CW-1:0]   w_eff;
  logic [IH_W-1:0] h_eff;
  logic [IR_W-1:0] rad_eff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(image_width) > WIDTH_MAX) begin
      w_eff = CW'(WIDTH_MAX);
    end else begin
      w_eff = CW'(image_width);
    end
    h_eff   = (image_height == '0) ? IH_W'(1) : image_height;
    rad_eff = (32'(radius) > RADIUS_MAX) ? IR_W'(RADIUS_MAX) : radius;
  end

  // input side: wrap of a column left past a changed width
  logic [CW-1:0]   icol_w, icol_n;
  logic [IH_W:0]   irow_w, irow_n;
  logic [RW-1:0]   iring_w, iring_n;
  logic            in_acc, do_write, frame_done;

  always_comb begin
    in_acc = in_valid && in_ready;
    if (in_column >= w_eff) begin
      icol_w  = '0;
      irow_w  = {1'b0, in_row} + 1'b1;
      iring_w = (in_ring == RW'(RING - 1)) ? '0 : in_ring + 1'b1;
    end else begin
      icol_w  = in_column;
      irow_w  = {1'b0, in_row};
      iring_w = in_ring;
    end
    frame_done = irow_w >= {1'b0, h_eff};
    do_write   = in_acc && (cmd == CMD_PIXEL) && !frame_done;
    if (icol_w + 1'b1 >= w_eff) begin
      icol_n  = '0;
      irow_n  = irow_w + 1'b1;
      iring_n = (iring_w == RW'(RING - 1)) ? '0 : iring_w + 1'b1;
    end else begin
      icol_n  = icol_w + 1'b1;
      irow_n  = irow_w;
      iring_n = iring_w;
    end
  end

  // window bounds of the next output and ring row of its top
  logic [IH_W-1:0] rlo_c, rhi_c;
  logic [IH_W:0]   rsum;
  logic [CW-1:0]   clo_c, chi_c;
  logic [CW:0]     csum;
  logic [RW-1:0]   ring_c;

  always_comb begin
    rlo_c = (out_row > IH_W'(rad_eff)) ? out_row - IH_W'(rad_eff) : '0;
    rsum  = {1'b0, out_row} + (IH_W + 1)'(rad_eff);
    rhi_c = (rsum < {1'b0, h_eff}) ? rsum[IH_W-1:0] : h_eff - 1'b1;
    clo_c = (out_column > CW'(rad_eff)) ? out_column - CW'(rad_eff) : '0;
    csum  = {1'b0, out_column} + (CW + 1)'(rad_eff);
    chi_c = (csum < {1'b0, w_eff}) ? csum[CW-1:0] : w_eff - 1'b1;
    if (out_row > IH_W'(rad_eff)) begin
      ring_c = (out_ring >= RW'(rad_eff)) ? out_ring - RW'(rad_eff)
                                          : out_ring + RW'(RING) - RW'(rad_eff);
    end else begin
      ring_c = '0;
    end
  end

  // output side advance
  logic [CW-1:0] ocol_n;
  logic [IH_W:0] orow_n;
  logic [RW-1:0] oring_n;
  logic          last_n;

  always_comb begin
    if (out_column + 1'b1 >= w_eff) begin
      ocol_n  = '0;
      orow_n  = {1'b0, out_row} + 1'b1;
      oring_n = (out_ring == RW'(RING - 1)) ? '0 : out_ring + 1'b1;
    end else begin
      ocol_n  = out_column + 1'b1;
      orow_n  = {1'b0, out_row};
      oring_n = out_ring;
    end
    last_n = orow_n >= {1'b0, h_eff};
  end

  // serial divider for the mean
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_q;

  assign div_start = (state == ST_DIVS);

  bben_div #(.DW(SUM_W), .NW(NW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sum),
    .divisor   (count),
    .done      (div_done),
    .quotient  (div_q)
  );

  // row store
  logic             rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] rd_data;

  assign rd_en   = (state == ST_SUM);
  assign wr_addr = AW'(32'(iring_w) * WIDTH_MAX + 32'(icol_w[XW-1:0]));
  assign rd_addr = AW'(32'(ri) * WIDTH_MAX + 32'(col[XW-1:0]));

  bben_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (wr_addr),
    .wr_data (pixel_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IW_W'(1024);
      image_height <= IH_W'(1024);
      radius       <= IR_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[IW_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[IH_W-1:0];
        REG_RADIUS: radius       <= cfg_data[IR_W-1:0];
        default: ;
      endcase
    end
  end

  // window scan accumulate flag, set in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= rd_en;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_column  <= '0;
      in_row     <= '0;
      in_ring    <= '0;
      out_column <= '0;
      out_row    <= '0;
      out_ring   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // output register: load when free or being emptied
      if ((state == ST_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (rd_pending) begin
        sum <= sum + SUM_W'(rd_data);
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (do_write) begin
              in_column <= icol_n;
              in_row    <= irow_n[IH_W-1:0];
              in_ring   <= iring_n;
              state     <= ST_MUL;
            end else begin
              in_column <= icol_w;
              in_row    <= irow_w[IH_W-1:0];
              in_ring   <= iring_w;
              state     <= frame_done ? ST_WRAP : ST_IDLE;
            end
          end
        end
        ST_MUL: begin
          prod_in  <= PW'(32'(in_row) * 32'(w_eff));
          prod_out <= PW'(32'(out_row) * 32'(w_eff));
          lag      <= PW'(32'(rad_eff) * 32'(w_eff) + 32'(rad_eff));
          state    <= ST_CMP;
        end
        ST_CMP: begin
          if (prod_in + PW'(in_column) > prod_out + PW'(out_column) + lag) begin
            state <= ST_WRAP;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_WRAP: begin
          if (out_column >= w_eff) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
            out_ring   <= (out_ring == RW'(RING - 1)) ? '0 : out_ring + 1'b1;
          end
          state <= ST_WIN;
        end
        ST_WIN: begin
          rlo        <= rlo_c;
          rhi        <= rhi_c;
          clo        <= clo_c;
          chi        <= chi_c;
          ring_start <= ring_c;
          if ((rlo_c > rhi_c) || (clo_c > chi_c)) begin
            value <= '0;
            state <= ST_FIN;
          end else begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          count <= NW'((32'(rhi) - 32'(rlo) + 1) * (32'(chi) - 32'(clo) + 1));
          ri    <= ring_start;
          rr    <= rlo;
          col   <= clo;
          sum   <= '0;
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (rr == rhi) begin
            if (col == chi) begin
              state <= ST_SUMW;
            end else begin
              col <= col + 1'b1;
              rr  <= rlo;
              ri  <= ring_start;
            end
          end else begin
            rr <= rr + 1'b1;
            ri <= (ri == RW'(RING - 1)) ? '0 : ri + 1'b1;
          end
        end
        ST_SUMW: begin
          state <= ST_DIVS;
        end
        ST_DIVS: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            value <= div_q[PIX_W-1:0];
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          is_last <= last_n;
          if (last_n) begin
            in_column  <= '0;
            in_row     <= '0;
            in_ring    <= '0;
            out_column <= '0;
            out_row    <= '0;
            out_ring   <= '0;
          end else begin
            out_column <= ocol_n;
            out_row    <= orow_n[IH_W-1:0];
            out_ring   <= oring_n;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            pixel_out  <= value;
            frame_last <= is_last;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bben_store.sv */
module bben_store import bben_pkg::*; #(
  parameter int DEPTH = RADIUS_MAX_DEF * 2 * WIDTH_MAX_DEF + WIDTH_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bben_div.sv */
module bben_div import bben_pkg::*; #(
  parameter int DW = SUM_W,
  parameter int NW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int KW = $clog2(DW + 1);

  logic          busy;
  logic [KW-1:0] cnt;
  logic [DW-1:0] q;
  logic [NW:0]   r;
  logic [NW:0]   rs;
  logic          fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    rs   = {r[NW-1:0], q[DW-1]};
    fits = rs >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        r    <= '0;
      end else if (busy) begin
        q <= {q[DW-2:0], fits};
        r <= fits ? rs - {1'b0, divisor} : rs;
        if (cnt == KW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign quotient = q;

endmodule

/* verif/box_blur_edge_normalized_tb.sv */
module box_blur_edge_normalized_tb;
  import bben_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_ROWS   = 2 * RADIUS_MAX_DEF + 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 400;
  localparam int HOLD_CYCLES = 2500;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } mean_t;

  typedef struct {
    logic             c;
    logic [PIX_W-1:0] pix;
    bit               typed;
    mean_t            want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  cmd;
  logic [PIX_W-1:0]      pixel_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      pixel_out;
  logic                  frame_last;

  box_blur_edge_normalized uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_out(pixel_out),
    .frame_last(frame_last)
  );

  // clock
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // predictor state: registers, pixel ring and position counters
  int unsigned      reg_w = 1024, reg_h = 1024, reg_r = 1;
  logic [PIX_W-1:0] ring [0:RING_ROWS*WIDTH_MAX_DEF-1];
  int unsigned      col_in, row_in, col_out, row_out;

  mean_t expected_means[$];
  int    errors = 0;
  int    items_sent = 0;
  bit    steady = 0;
  int    holds_wanted = 0;

  function automatic int unsigned eff_w();
    if (reg_w == 0) return 1;
    if (reg_w > WIDTH_MAX_DEF) return WIDTH_MAX_DEF;
    return reg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (reg_h == 0) ? 1 : reg_h;
  endfunction

  function automatic int unsigned eff_r();
    return (reg_r > RADIUS_MAX_DEF) ? RADIUS_MAX_DEF : reg_r;
  endfunction

  // clipped window sum divided by the number of pixels inside
  function automatic logic [PIX_W-1:0] window_mean(int unsigned r, int unsigned c);
    int unsigned w, h, rad, rlo, rhi, clo, chi, acc, cnt;
    w = eff_w(); h = eff_h(); rad = eff_r();
    rlo = (r > rad) ? r - rad : 0;
    rhi = (r + rad < h) ? r + rad : h - 1;
    clo = (c > rad) ? c - rad : 0;
    chi = (c + rad < w) ? c + rad : w - 1;
    acc = 0;
    if (rlo > rhi || clo > chi) return '0;
    for (int unsigned x = clo; x <= chi; x++)
      for (int unsigned y = rlo; y <= rhi; y++)
        acc = (acc + ring[(y % RING_ROWS) * WIDTH_MAX_DEF + x]) & 32'h1FF_FFFF;
    cnt = (rhi - rlo + 1) * (chi - clo + 1);
    return PIX_W'((acc / cnt) & 32'hFFFF);
  endfunction

  // produce the next output pixel and advance the output position
  function automatic mean_t next_mean();
    mean_t m;
    int unsigned w, h;
    w = eff_w(); h = eff_h();
    if (col_out >= w) begin col_out = 0; row_out++; end
    m.pix = window_mean(row_out, col_out);
    col_out++;
    if (col_out >= w) begin col_out = 0; row_out++; end
    m.last = (row_out >= h);
    if (m.last) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end
    return m;
  endfunction

  // one accepted transaction; returns 1 when it releases an output pixel
  function automatic bit blur_step(input logic c, input logic [PIX_W-1:0] p,
                                   output mean_t m);
    int unsigned w, h, rad, got, due;
    w = eff_w(); h = eff_h(); rad = eff_r();
    m = '0;
    if (col_in >= w) begin col_in = 0; row_in++; end
    if (c == CMD_DRAIN || row_in >= h) begin
      if (row_in >= h) begin
        m = next_mean();
        return 1;
      end
      return 0;
    end
    ring[(row_in % RING_ROWS) * WIDTH_MAX_DEF + col_in] = p;
    col_in++;
    if (col_in >= w) begin col_in = 0; row_in++; end
    got = row_in * w + col_in;
    due = row_out * w + col_out + rad * w + rad;
    if (got > due) begin
      m = next_mean();
      return 1;
    end
    return 0;
  endfunction

  // input side: random gap, then hold valid until the transaction
  task automatic send_item(input logic c, input logic [PIX_W-1:0] p,
                           input bit typed, input mean_t want);
    int    gap;
    bit    got;
    mean_t m;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    got = blur_step(c, p, m);
    if (typed) expected_means.push_back(want);
    else if (got) expected_means.push_back(m);
    items_sent++;
  endtask

  // register write; valid is lowered by the caller
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  reg_w = val & 32'h7FF;
      REG_HEIGHT: reg_h = val & 32'h1FFF;
      REG_RADIUS: reg_r = val & 32'hF;
      default: ;
    endcase
  endtask

  // wait until idle, then program the frame geometry
  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned r, input bit junk);
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    if (junk) write_reg(2'd3, $urandom_range(0, 8191));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // whole frames: pixels with stray drains, then drains for pending outputs
  task automatic run_frames(input int n);
    int unsigned w, h, rad;
    w = eff_w(); h = eff_h(); rad = eff_r();
    for (int f = 0; f < n; f++) begin
      for (int unsigned i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 19) == 0) send_item(CMD_DRAIN, rand_pixel(), 0, '0);
        send_item(CMD_PIXEL, rand_pixel(), 0, '0);
      end
      for (int unsigned k = 0; k < rad * w + rad; k++) begin
        if ($urandom_range(0, 3) == 0) send_item(CMD_PIXEL, rand_pixel(), 0, '0);
        else send_item(CMD_DRAIN, rand_pixel(), 0, '0);
      end
      if ($urandom_range(0, 1) == 0) send_item(CMD_DRAIN, rand_pixel(), 0, '0);
    end
  endtask

  // output side: random stalls, long hold-off on request, compare fields
  int hold_left = 0, wait_left = 0, holds_served = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected output pixel_out=%h frame_last=%b",
                   $realtime, pixel_out, frame_last);
          errors++;
        end else begin
          mean_t e;
          e = expected_means.pop_front();
          if (pixel_out !== e.pix) begin
            $display("%0t: pixel_out expected %h actual %h", $realtime, e.pix, pixel_out);
            errors++;
          end
          if (frame_last !== e.last) begin
            $display("%0t: frame_last expected %b actual %b", $realtime, e.last, frame_last);
            errors++;
          end
        end
        wait_left = steady ? 0 : $urandom_range(0, 3);
      end
      if (holds_served != holds_wanted) begin
        holds_served = holds_wanted;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // directed rows: one-pixel frames with typed results, then a 4x4 frame
  stim_row_t rows [$];

  task automatic add_row(input logic c, input logic [PIX_W-1:0] p, input bit typed,
                         input logic [PIX_W-1:0] epix, input logic elast);
    stim_row_t s;
    s.c = c; s.pix = p; s.typed = typed; s.want.pix = epix; s.want.last = elast;
    rows.push_back(s);
  endtask

  initial begin
    int unsigned r, w, h;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cmd       <= CMD_PIXEL;
    pixel_in  <= '0;
    for (int i = 0; i < RING_ROWS * WIDTH_MAX_DEF; i++) ring[i] = '0;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // width 0 and height 0 act as 1: each pixel is its own frame
    add_row(CMD_PIXEL, 16'hFFFF, 1, 16'hFFFF, 1'b1);
    add_row(CMD_PIXEL, 16'h0000, 1, 16'h0000, 1'b1);
    add_row(CMD_DRAIN, 16'h5A5A, 0, '0, 1'b0);
    add_row(CMD_PIXEL, 16'h8001, 1, 16'h8001, 1'b1);
    // 4x4 radius 1 frame, then a pixel acting as drain, drains, idle drain
    for (int i = 0; i < 16; i++)
      add_row(CMD_PIXEL, (i % 3 == 0) ? 16'hFFFF : PIX_W'(257 * i), 0, '0, 1'b0);
    add_row(CMD_PIXEL, 16'h1234, 0, '0, 1'b0);
    for (int i = 0; i < 5; i++) add_row(CMD_DRAIN, '0, 0, '0, 1'b0);

    configure(0, 8191, 15, 1);
    configure(0, 0, 0, 0);
    foreach (rows[i]) begin
      if (i == 4) configure(4, 4, 1, 0);
      send_item(rows[i].c, rows[i].pix, rows[i].typed, rows[i].want);
    end

    // extremes: widest row, largest radius
    configure(2047, 1, 0, 0);
    run_frames(1);
    configure(18, 18, 15, 0);
    run_frames(1);

    // random geometries, some without idling, one with a long output hold-off
    for (int ph = 0; ph < 2; ph++) begin
      r = $urandom_range(0, 3);
      w = $urandom_range(2 * r + 2, 2 * r + 10);
      h = $urandom_range(2 * r + 2, 2 * r + 5);
      configure(w, h, r, 0);
      steady = ($urandom_range(0, 3) == 0);
      if (ph == 1) holds_wanted++;
      run_frames($urandom_range(1, 2));
      steady = 0;
    end

    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
